// ----- rtl/kmc_pkg.sv -----
// Shared types and constants of the two-cluster k-means engine.
package kmc_pkg;

    localparam int INDEX_BITS = 8;
    localparam int PASS_BITS  = 10;

    localparam logic [PASS_BITS-1:0] PASS_LIMIT_RESET = 10'd64;

    localparam logic [2:0] CALC_LAST_STEP = 3'd4;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_RUN  = 2'd1,
        MODE_READ = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_FEW_POINTS = 2'd1;
    localparam logic [1:0] STATUS_BAD_INDEX  = 2'd2;

    typedef struct packed {
        logic       mul_en;
        logic [1:0] term;
        logic       acc_en;
    } dist_ctrl_t;

    typedef struct packed {
        logic pt_wr;
        logic pt_rd;
        logic lbl_wr;
        logic lbl_wr_data;
        logic lbl_rd;
    } store_ctrl_t;

endpackage

// ----- rtl/two_cluster_online_kmeans.sv -----
// Top level of the two-cluster k-means engine: sequencer, centroids and word ports.
// Load: one word per cycle, no result. Read label: the label store read is registered,
// then the result register is written from the result state once the output is free.
// Run: seed A, seed B and pass start, then per point the shared squarer's five steps
// and one update step, and a pass-end step per pass. No new word while a read or run is in progress.
// rst_n clears control state, centroids and counts; the stores need no clearing.
module two_cluster_online_kmeans
    import kmc_pkg::*;
#(
    parameter int MAX_POINTS = 256,
    parameter int COORD_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   mode,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic [INDEX_BITS-1:0]        point_index,
    input  logic                         cfg_wr_en,
    input  logic [PASS_BITS-1:0]         cfg_wr_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS-1:0] centroid_a_x,
    output logic signed [COORD_BITS-1:0] centroid_a_y,
    output logic signed [COORD_BITS-1:0] centroid_b_x,
    output logic signed [COORD_BITS-1:0] centroid_b_y,
    output logic                         label,
    output logic [PASS_BITS-1:0]         passes_used,
    output logic                         converged,
    output logic [1:0]                   status
);

    localparam int C    = COORD_BITS;
    localparam int AW   = $clog2(MAX_POINTS);
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int CMPW = (CW > INDEX_BITS) ? CW : INDEX_BITS;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_A,
        ST_SEED_B,
        ST_PASS_START,
        ST_CALC,
        ST_UPDATE,
        ST_PASS_END,
        ST_RESULT
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0]        count_reg, count_next;
    logic                 fresh_reg, fresh_next;
    logic [PASS_BITS-1:0] limit_reg, limit_next;
    logic [PASS_BITS-1:0] pass_reg, pass_next;
    logic                 conv_reg, conv_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [2:0]           step_reg, step_next;
    logic [1:0]           res_status_reg, res_status_next;
    logic                 res_read_reg, res_read_next;

    logic signed [C-1:0] ca_x_reg, ca_x_next, ca_y_reg, ca_y_next;
    logic signed [C-1:0] cb_x_reg, cb_x_next, cb_y_reg, cb_y_next;
    logic signed [C-1:0] pa_x_reg, pa_x_next, pa_y_reg, pa_y_next;
    logic signed [C-1:0] pb_x_reg, pb_x_next, pb_y_reg, pb_y_next;

    logic                 out_valid_reg, out_valid_next;
    logic signed [C-1:0]  out_ca_x_reg, out_ca_x_next, out_ca_y_reg, out_ca_y_next;
    logic signed [C-1:0]  out_cb_x_reg, out_cb_x_next, out_cb_y_reg, out_cb_y_next;
    logic                 out_label_reg, out_label_next;
    logic [PASS_BITS-1:0] out_passes_reg, out_passes_next;
    logic                 out_conv_reg, out_conv_next;
    logic [1:0]           out_status_reg, out_status_next;

    store_ctrl_t         sctl;
    dist_ctrl_t          dctl;
    logic [AW-1:0]       load_addr;
    logic [AW-1:0]       pt_rd_addr;
    logic [AW-1:0]       lbl_wr_addr;
    logic [AW-1:0]       lbl_rd_addr;
    logic [2*C-1:0]      pt_rd_data;
    logic                lbl_rd_data;
    logic signed [C-1:0] pt_x;
    logic signed [C-1:0] pt_y;
    logic                sel_b;

    logic                in_accept;
    logic                out_free;
    logic [CMPW-1:0]     idx_wide;
    logic [CMPW-1:0]     cnt_wide;
    logic [CW-1:0]       idx_plus;
    logic [PASS_BITS:0]  pass_plus;
    logic [PASS_BITS:0]  limit_eff;
    logic signed [C-1:0] upd_cx;
    logic signed [C-1:0] upd_cy;
    logic signed [C:0]   sum_x;
    logic signed [C:0]   sum_y;
    logic signed [C-1:0] new_cx;
    logic signed [C-1:0] new_cy;
    logic                stable;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign idx_wide  = CMPW'(point_index);
    assign cnt_wide  = CMPW'(count_reg);
    assign idx_plus  = CW'(idx_reg) + CW'(1);
    assign pass_plus = {1'b0, pass_reg} + (PASS_BITS + 1)'(1);
    assign limit_eff = (limit_reg == '0) ? (PASS_BITS + 1)'(1) : {1'b0, limit_reg};
    assign load_addr = fresh_reg ? '0 : AW'(count_reg);

    assign pt_x = pt_rd_data[C-1:0];
    assign pt_y = pt_rd_data[2*C-1:C];

    assign upd_cx = sel_b ? cb_x_reg : ca_x_reg;
    assign upd_cy = sel_b ? cb_y_reg : ca_y_reg;
    assign sum_x  = {upd_cx[C-1], upd_cx} + {pt_x[C-1], pt_x};
    assign sum_y  = {upd_cy[C-1], upd_cy} + {pt_y[C-1], pt_y};
    assign new_cx = sum_x[C:1];
    assign new_cy = sum_y[C:1];

    assign stable = (ca_x_reg == pa_x_reg) && (ca_y_reg == pa_y_reg)
                 && (cb_x_reg == pb_x_reg) && (cb_y_reg == pb_y_reg);

    kmc_store #(
        .DEPTH     (MAX_POINTS),
        .DATA_BITS (2 * C),
        .AW        (AW)
    ) u_store (
        .clk         (clk),
        .ctrl        (sctl),
        .pt_wr_addr  (load_addr),
        .pt_wr_data  ({point_y, point_x}),
        .pt_rd_addr  (pt_rd_addr),
        .pt_rd_data  (pt_rd_data),
        .lbl_wr_addr (lbl_wr_addr),
        .lbl_rd_addr (lbl_rd_addr),
        .lbl_rd_data (lbl_rd_data)
    );

    kmc_dist #(
        .COORD_BITS (C)
    ) u_dist (
        .clk   (clk),
        .ctrl  (dctl),
        .ca_x  (ca_x_reg),
        .ca_y  (ca_y_reg),
        .cb_x  (cb_x_reg),
        .cb_y  (cb_y_reg),
        .p_x   (pt_x),
        .p_y   (pt_y),
        .sel_b (sel_b)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        fresh_next      = fresh_reg;
        limit_next      = limit_reg;
        pass_next       = pass_reg;
        conv_next       = conv_reg;
        idx_next        = idx_reg;
        step_next       = step_reg;
        res_status_next = res_status_reg;
        res_read_next   = res_read_reg;
        ca_x_next       = ca_x_reg;
        ca_y_next       = ca_y_reg;
        cb_x_next       = cb_x_reg;
        cb_y_next       = cb_y_reg;
        pa_x_next       = pa_x_reg;
        pa_y_next       = pa_y_reg;
        pb_x_next       = pb_x_reg;
        pb_y_next       = pb_y_reg;
        out_valid_next  = out_valid_reg;
        out_ca_x_next   = out_ca_x_reg;
        out_ca_y_next   = out_ca_y_reg;
        out_cb_x_next   = out_cb_x_reg;
        out_cb_y_next   = out_cb_y_reg;
        out_label_next  = out_label_reg;
        out_passes_next = out_passes_reg;
        out_conv_next   = out_conv_reg;
        out_status_next = out_status_reg;
        sctl            = '0;
        dctl            = '0;
        pt_rd_addr      = '0;
        lbl_wr_addr     = load_addr;
        lbl_rd_addr     = AW'(idx_wide);

        if (cfg_wr_en)
        begin
            limit_next = cfg_wr_data;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (mode_t'(mode))
                        MODE_LOAD:
                        begin
                            fresh_next = 1'b0;
                            if (fresh_reg || (count_reg < MAX_CNT))
                            begin
                                sctl.pt_wr  = 1'b1;
                                sctl.lbl_wr = 1'b1;
                                count_next  = (fresh_reg ? '0 : count_reg) + CW'(1);
                            end
                        end
                        MODE_RUN:
                        begin
                            fresh_next = 1'b1;
                            if (count_reg < CW'(2))
                            begin
                                pass_next       = '0;
                                conv_next       = 1'b0;
                                res_status_next = STATUS_FEW_POINTS;
                                res_read_next   = 1'b0;
                                state_next      = ST_RESULT;
                            end
                            else
                            begin
                                sctl.pt_rd = 1'b1;
                                state_next = ST_SEED_A;
                            end
                        end
                        MODE_READ:
                        begin
                            sctl.lbl_rd     = 1'b1;
                            res_read_next   = 1'b1;
                            res_status_next = (idx_wide < cnt_wide) ? STATUS_OK
                                                                    : STATUS_BAD_INDEX;
                            state_next      = ST_RESULT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SEED_A:
            begin
                ca_x_next  = pt_x;
                ca_y_next  = pt_y;
                sctl.pt_rd = 1'b1;
                pt_rd_addr = AW'(1);
                state_next = ST_SEED_B;
            end
            ST_SEED_B:
            begin
                cb_x_next  = pt_x;
                cb_y_next  = pt_y;
                pass_next  = '0;
                conv_next  = 1'b0;
                state_next = ST_PASS_START;
            end
            ST_PASS_START:
            begin
                pa_x_next  = ca_x_reg;
                pa_y_next  = ca_y_reg;
                pb_x_next  = cb_x_reg;
                pb_y_next  = cb_y_reg;
                idx_next   = '0;
                step_next  = '0;
                sctl.pt_rd = 1'b1;
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                dctl.mul_en = (step_reg != CALC_LAST_STEP);
                dctl.term   = step_reg[1:0];
                dctl.acc_en = (step_reg != '0);
                step_next   = step_reg + 3'd1;
                if (step_reg == CALC_LAST_STEP)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (sel_b)
                begin
                    cb_x_next = new_cx;
                    cb_y_next = new_cy;
                end
                else
                begin
                    ca_x_next = new_cx;
                    ca_y_next = new_cy;
                end
                sctl.lbl_wr      = 1'b1;
                sctl.lbl_wr_data = sel_b;
                lbl_wr_addr      = idx_reg;
                if (idx_plus < count_reg)
                begin
                    sctl.pt_rd = 1'b1;
                    pt_rd_addr = AW'(idx_plus);
                    idx_next   = AW'(idx_plus);
                    step_next  = '0;
                    state_next = ST_CALC;
                end
                else
                begin
                    state_next = ST_PASS_END;
                end
            end
            ST_PASS_END:
            begin
                pass_next       = PASS_BITS'(pass_plus);
                res_status_next = STATUS_OK;
                res_read_next   = 1'b0;
                if (stable)
                begin
                    conv_next  = 1'b1;
                    state_next = ST_RESULT;
                end
                else if (pass_plus >= limit_eff)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    pa_x_next  = ca_x_reg;
                    pa_y_next  = ca_y_reg;
                    pb_x_next  = cb_x_reg;
                    pb_y_next  = cb_y_reg;
                    idx_next   = '0;
                    step_next  = '0;
                    sctl.pt_rd = 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_ca_x_next   = ca_x_reg;
                    out_ca_y_next   = ca_y_reg;
                    out_cb_x_next   = cb_x_reg;
                    out_cb_y_next   = cb_y_reg;
                    out_label_next  = res_read_reg && (res_status_reg == STATUS_OK)
                                      && lbl_rd_data;
                    out_passes_next = pass_reg;
                    out_conv_next   = conv_reg;
                    out_status_next = res_status_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            fresh_reg      <= 1'b1;
            limit_reg      <= PASS_LIMIT_RESET;
            pass_reg       <= '0;
            conv_reg       <= 1'b0;
            idx_reg        <= '0;
            step_reg       <= '0;
            res_status_reg <= STATUS_OK;
            res_read_reg   <= 1'b0;
            ca_x_reg       <= '0;
            ca_y_reg       <= '0;
            cb_x_reg       <= '0;
            cb_y_reg       <= '0;
            pa_x_reg       <= '0;
            pa_y_reg       <= '0;
            pb_x_reg       <= '0;
            pb_y_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            fresh_reg      <= fresh_next;
            limit_reg      <= limit_next;
            pass_reg       <= pass_next;
            conv_reg       <= conv_next;
            idx_reg        <= idx_next;
            step_reg       <= step_next;
            res_status_reg <= res_status_next;
            res_read_reg   <= res_read_next;
            ca_x_reg       <= ca_x_next;
            ca_y_reg       <= ca_y_next;
            cb_x_reg       <= cb_x_next;
            cb_y_reg       <= cb_y_next;
            pa_x_reg       <= pa_x_next;
            pa_y_reg       <= pa_y_next;
            pb_x_reg       <= pb_x_next;
            pb_y_reg       <= pb_y_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_ca_x_reg   <= out_ca_x_next;
        out_ca_y_reg   <= out_ca_y_next;
        out_cb_x_reg   <= out_cb_x_next;
        out_cb_y_reg   <= out_cb_y_next;
        out_label_reg  <= out_label_next;
        out_passes_reg <= out_passes_next;
        out_conv_reg   <= out_conv_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid    = out_valid_reg;
    assign centroid_a_x = out_ca_x_reg;
    assign centroid_a_y = out_ca_y_reg;
    assign centroid_b_x = out_cb_x_reg;
    assign centroid_b_y = out_cb_y_reg;
    assign label        = out_label_reg;
    assign passes_used  = out_passes_reg;
    assign converged    = out_conv_reg;
    assign status       = out_status_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("point count beyond store depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CALC || state_reg == ST_UPDATE) |-> (CW'(idx_reg) < count_reg))
        else $error("pass index beyond loaded points");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RESULT))
        else $error("result word written outside result state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_conv_reg) |-> (out_passes_reg != '0))
        else $error("converged word reports zero passes");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CALC) |-> (step_reg <= CALC_LAST_STEP))
        else $error("distance step counter out of range");

endmodule

// ----- rtl/kmc_store.sv -----
// Point store and label store with registered read ports.
module kmc_store
    import kmc_pkg::*;
#(
    parameter int DEPTH     = 256,
    parameter int DATA_BITS = 32,
    parameter int AW        = 8
)
(
    input  logic                 clk,
    input  store_ctrl_t          ctrl,
    input  logic [AW-1:0]        pt_wr_addr,
    input  logic [DATA_BITS-1:0] pt_wr_data,
    input  logic [AW-1:0]        pt_rd_addr,
    output logic [DATA_BITS-1:0] pt_rd_data,
    input  logic [AW-1:0]        lbl_wr_addr,
    input  logic [AW-1:0]        lbl_rd_addr,
    output logic                 lbl_rd_data
);

    logic [DATA_BITS-1:0] pt_mem [DEPTH];
    logic                 lbl_mem [DEPTH];
    logic [DATA_BITS-1:0] pt_rd_data_reg;
    logic                 lbl_rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.pt_wr)
        begin
            pt_mem[pt_wr_addr] <= pt_wr_data;
        end
        if (ctrl.pt_rd)
        begin
            pt_rd_data_reg <= pt_mem[pt_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.lbl_wr)
        begin
            lbl_mem[lbl_wr_addr] <= ctrl.lbl_wr_data;
        end
        if (ctrl.lbl_rd)
        begin
            lbl_rd_data_reg <= lbl_mem[lbl_rd_addr];
        end
    end

    assign pt_rd_data  = pt_rd_data_reg;
    assign lbl_rd_data = lbl_rd_data_reg;

endmodule

// ----- rtl/kmc_dist.sv -----
// Shared squarer and accumulator that builds both squared distances of a point.
module kmc_dist
    import kmc_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                         clk,
    input  dist_ctrl_t                   ctrl,
    input  logic signed [COORD_BITS-1:0] ca_x,
    input  logic signed [COORD_BITS-1:0] ca_y,
    input  logic signed [COORD_BITS-1:0] cb_x,
    input  logic signed [COORD_BITS-1:0] cb_y,
    input  logic signed [COORD_BITS-1:0] p_x,
    input  logic signed [COORD_BITS-1:0] p_y,
    output logic                         sel_b
);

    localparam int MW = COORD_BITS + 1;
    localparam int PW = 2 * MW;
    localparam int DW = PW + 1;

    logic signed [COORD_BITS-1:0] opa;
    logic signed [COORD_BITS-1:0] opb;
    logic signed [MW-1:0]         diff;
    logic        [MW-1:0]         mag;
    logic        [PW-1:0]         prod_reg;
    logic        [1:0]            prod_term_reg;
    logic        [DW-1:0]         dist_a_reg;
    logic        [DW-1:0]         dist_b_reg;
    logic        [DW-1:0]         acc_src;
    logic        [DW-1:0]         acc_sum;

    always_comb
    begin
        case (ctrl.term)
            2'd0:    begin opa = ca_x; opb = p_x; end
            2'd1:    begin opa = ca_y; opb = p_y; end
            2'd2:    begin opa = cb_x; opb = p_x; end
            default: begin opa = cb_y; opb = p_y; end
        endcase
    end

    assign diff = MW'(opa) - MW'(opb);
    assign mag  = diff[MW-1] ? MW'(-diff) : MW'(diff);

    assign acc_src = prod_term_reg[1] ? dist_b_reg : dist_a_reg;
    assign acc_sum = prod_term_reg[0] ? acc_src + DW'(prod_reg) : DW'(prod_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg      <= mag * mag;
            prod_term_reg <= ctrl.term;
        end
        if (ctrl.acc_en)
        begin
            if (prod_term_reg[1])
            begin
                dist_b_reg <= acc_sum;
            end
            else
            begin
                dist_a_reg <= acc_sum;
            end
        end
    end

    assign sel_b = !(dist_a_reg < dist_b_reg);

endmodule

// ----- verif/tb_two_cluster_online_kmeans.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the two-cluster k-means engine: directed and random words with a behavioral model.
module tb_two_cluster_online_kmeans;
    import kmc_pkg::*;

    localparam int MAX_POINTS   = 256;
    localparam int COORD_BITS   = 16;
    localparam int RANDOM_WORDS = 550;
    localparam int SETTLE       = 8;
    localparam int STALL_LIMIT  = 400000;
    localparam int MAX_PRINTS   = 100;

    typedef struct {
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
        logic                         lbl;
        logic [PASS_BITS-1:0]         passes;
        logic                         conv;
        logic [1:0]                   st;
    } cluster_report_t;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic [1:0]                   mode;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic [INDEX_BITS-1:0]        point_index;
    logic                         cfg_wr_en;
    logic [PASS_BITS-1:0]         cfg_wr_data;
    logic                         out_valid;
    logic                         out_stall;
    logic signed [COORD_BITS-1:0] centroid_a_x;
    logic signed [COORD_BITS-1:0] centroid_a_y;
    logic signed [COORD_BITS-1:0] centroid_b_x;
    logic signed [COORD_BITS-1:0] centroid_b_y;
    logic                         label;
    logic [PASS_BITS-1:0]         passes_used;
    logic                         converged;
    logic [1:0]                   status;

    int               pts_x [MAX_POINTS];
    int               pts_y [MAX_POINTS];
    bit               pt_label [MAX_POINTS];
    int               pt_count;
    int               cen [4];
    int               pass_cnt;
    bit               conv_flag;
    bit               fresh_set;
    logic [PASS_BITS-1:0] pass_lim;

    cluster_report_t  cluster_reports [$];
    int               mismatches;
    int               sent_words;
    bit               steady;
    int               hold_req;

    two_cluster_online_kmeans #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_index  (point_index),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .centroid_a_x (centroid_a_x),
        .centroid_a_y (centroid_a_y),
        .centroid_b_x (centroid_b_x),
        .centroid_b_y (centroid_b_y),
        .label        (label),
        .passes_used  (passes_used),
        .converged    (converged),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        if (steady)
            return 0;
        if ($urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    function automatic longint dist_sq(input int ax, input int ay, input int bx, input int by);
        longint dx;
        longint dy;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        return dx * dx + dy * dy;
    endfunction

    function automatic void run_clusters();
        int lim;
        int i;
        int k;
        int sel;
        int prev [4];
        bit same;
        lim = (pass_lim == 0) ? 1 : int'(pass_lim);
        cen[0] = pts_x[0];
        cen[1] = pts_y[0];
        cen[2] = pts_x[1];
        cen[3] = pts_y[1];
        pass_cnt  = 0;
        conv_flag = 1'b0;
        forever
        begin
            for (k = 0; k < 4; k++)
                prev[k] = cen[k];
            for (i = 0; i < pt_count; i++)
            begin
                sel = (dist_sq(cen[0], cen[1], pts_x[i], pts_y[i]) <
                       dist_sq(cen[2], cen[3], pts_x[i], pts_y[i])) ? 0 : 1;
                cen[2*sel]     = (cen[2*sel] + pts_x[i]) >>> 1;
                cen[2*sel + 1] = (cen[2*sel + 1] + pts_y[i]) >>> 1;
                pt_label[i]    = sel[0];
            end
            pass_cnt++;
            same = 1'b1;
            for (k = 0; k < 4; k++)
                if (prev[k] != cen[k])
                    same = 1'b0;
            if (same)
            begin
                conv_flag = 1'b1;
                break;
            end
            if (pass_cnt >= lim)
                break;
        end
    endfunction

    function automatic void apply_kmeans_word(input mode_t m,
                                              input logic signed [COORD_BITS-1:0] x,
                                              input logic signed [COORD_BITS-1:0] y,
                                              input logic [INDEX_BITS-1:0] idx);
        cluster_report_t r;
        r.lbl = 1'b0;
        r.st  = STATUS_OK;
        case (m)
            MODE_LOAD:
            begin
                if (fresh_set)
                begin
                    pt_count  = 0;
                    fresh_set = 1'b0;
                end
                if (pt_count < MAX_POINTS)
                begin
                    pts_x[pt_count]    = int'(x);
                    pts_y[pt_count]    = int'(y);
                    pt_label[pt_count] = 1'b0;
                    pt_count++;
                end
                return;
            end
            MODE_NONE:
                return;
            MODE_RUN:
            begin
                fresh_set = 1'b1;
                if (pt_count < 2)
                begin
                    pass_cnt  = 0;
                    conv_flag = 1'b0;
                    r.st      = STATUS_FEW_POINTS;
                end
                else
                    run_clusters();
            end
            default:
            begin
                if (int'(idx) < pt_count)
                    r.lbl = pt_label[idx];
                else
                    r.st = STATUS_BAD_INDEX;
            end
        endcase
        r.ax     = COORD_BITS'(cen[0]);
        r.ay     = COORD_BITS'(cen[1]);
        r.bx     = COORD_BITS'(cen[2]);
        r.by     = COORD_BITS'(cen[3]);
        r.passes = PASS_BITS'(pass_cnt);
        r.conv   = conv_flag;
        cluster_reports.insert(cluster_reports.size(), r);
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        if (mismatches < MAX_PRINTS)
            $display("%0t mismatch %s: got %0d expected %0d", $time, field, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string field, input longint got, input longint want);
        if (got != want)
            report_mismatch(field, got, want);
    endtask

    task automatic send_word(input mode_t m,
                             input logic signed [COORD_BITS-1:0] x,
                             input logic signed [COORD_BITS-1:0] y,
                             input logic [INDEX_BITS-1:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= m;
        point_x     <= x;
        point_y     <= y;
        point_index <= idx;
        do
            @(posedge clk);
        while (in_stall);
        if (m != MODE_NONE)
            sent_words++;
        apply_kmeans_word(m, x, y, idx);
    endtask

    task automatic load_point(input int x, input int y);
        send_word(MODE_LOAD, COORD_BITS'(x), COORD_BITS'(y), INDEX_BITS'($urandom()));
    endtask

    task automatic run_clustering();
        send_word(MODE_RUN, COORD_BITS'($urandom()), COORD_BITS'($urandom()),
                  INDEX_BITS'($urandom()));
    endtask

    task automatic read_label(input int idx);
        send_word(MODE_READ, COORD_BITS'($urandom()), COORD_BITS'($urandom()),
                  INDEX_BITS'(idx));
    endtask

    task automatic drain_block();
        in_valid <= 1'b0;
        while (cluster_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_pass_limit(input logic [PASS_BITS-1:0] value);
        drain_block();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        pass_lim    = value;
    endtask

    function automatic int rand_coord();
        return int'($signed(COORD_BITS'($urandom())));
    endfunction

    function automatic int near_coord(input int c, input int spread);
        int v;
        v = c + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v;
    endfunction

    task automatic test_too_few_points();
        run_clustering();
        read_label(0);
        load_point(1234, -4321);
        run_clustering();
        read_label(0);
        read_label(255);
    endtask

    task automatic test_extreme_coords();
        set_pass_limit(10'd0);
        load_point(32767, 32767);
        load_point(-32768, -32768);
        load_point(0, 0);
        load_point(-1, 1);
        read_label(3);
        run_clustering();
        read_label(0);
        read_label(1);
        read_label(2);
        read_label(3);
        read_label(4);
        send_word(MODE_NONE, COORD_BITS'($urandom()), COORD_BITS'($urandom()), 8'hff);
    endtask

    task automatic test_pass_limits();
        set_pass_limit(10'd1);
        load_point(5, 5);
        load_point(5, 5);
        run_clustering();
        read_label(1);
        set_pass_limit(10'd1023);
        load_point(-32768, 32767);
        load_point(32767, -32768);
        load_point(-32768, -32768);
        run_clustering();
        read_label(2);
        read_label(255);
    endtask

    task automatic test_store_full();
        int i;
        set_pass_limit(10'd2);
        for (i = 0; i <= MAX_POINTS; i++)
            load_point(rand_coord(), rand_coord());
        run_clustering();
        read_label(0);
        read_label(128);
        read_label(255);
    endtask

    task automatic test_backpressure();
        int i;
        set_pass_limit(10'd8);
        steady = 1'b1;
        for (i = 0; i < 4; i++)
            load_point(rand_coord(), rand_coord());
        hold_req = 300;
        run_clustering();
        for (i = 0; i < 8; i++)
            read_label($urandom_range(0, 5));
        steady = 1'b0;
    endtask

    task automatic test_random_sets();
        int start_words;
        int n;
        int i;
        int lim;
        int spread;
        int reads;
        int grp;
        int cx [2];
        int cy [2];
        bit clustered;
        start_words = sent_words;
        while (sent_words - start_words < RANDOM_WORDS)
        begin
            steady = ($urandom_range(0, 4) == 0);
            lim = -1;
            case ($urandom_range(0, 11))
                0:       lim = 1;
                1:       lim = fresh_set ? 1023 : 64;
                2, 3:    lim = $urandom_range(1, 16);
                4:       lim = $urandom_range(17, 64);
                default: ;
            endcase
            if (lim >= 0)
                set_pass_limit(PASS_BITS'(lim));
            if (pass_lim > 64)
                n = $urandom_range(2, 4);
            else
                case ($urandom_range(0, 19))
                    0:       n = $urandom_range(0, 1);
                    1:       n = $urandom_range(13, 40);
                    default: n = $urandom_range(2, 12);
                endcase
            clustered = ($urandom_range(0, 2) != 0);
            case ($urandom_range(0, 2))
                0:       spread = 3;
                1:       spread = 200;
                default: spread = 5000;
            endcase
            for (i = 0; i < 2; i++)
            begin
                cx[i] = rand_coord();
                cy[i] = rand_coord();
            end
            for (i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 24) == 0)
                begin
                    if ($urandom_range(0, 1) == 0)
                        send_word(MODE_NONE, COORD_BITS'($urandom()),
                                  COORD_BITS'($urandom()), INDEX_BITS'($urandom()));
                    else
                        read_label($urandom_range(0, 255));
                end
                grp = $urandom_range(0, 1);
                if (clustered)
                    load_point(near_coord(cx[grp], spread), near_coord(cy[grp], spread));
                else
                    load_point(rand_coord(), rand_coord());
            end
            if (pass_lim > 64 || $urandom_range(0, 9) != 0)
                run_clustering();
            if ($urandom_range(0, 7) == 0)
                run_clustering();
            reads = $urandom_range(1, 4);
            for (i = 0; i < reads; i++)
                if (n > 0 && $urandom_range(0, 4) != 0)
                    read_label($urandom_range(0, n - 1));
                else
                    read_label($urandom_range(0, 255));
        end
        steady = 1'b0;
    endtask

    initial
    begin : result_checker
        cluster_report_t r;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (cluster_reports.size() == 0)
                    report_mismatch("unrequested result", 1, 0);
                else
                begin
                    r = cluster_reports.pop_front();
                    check_field("centroid_a_x", longint'(centroid_a_x), longint'(r.ax));
                    check_field("centroid_a_y", longint'(centroid_a_y), longint'(r.ay));
                    check_field("centroid_b_x", longint'(centroid_b_x), longint'(r.bx));
                    check_field("centroid_b_y", longint'(centroid_b_y), longint'(r.by));
                    check_field("label", longint'(label), longint'(r.lbl));
                    check_field("passes_used", longint'(passes_used), longint'(r.passes));
                    check_field("converged", longint'(converged), longint'(r.conv));
                    check_field("status", longint'(status), longint'(r.st));
                end
            end
        end
    end

    initial
    begin : result_receiver
        int w;
        out_stall <= 1'b1;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req > 0)
            begin
                w = hold_req;
                hold_req = 0;
            end
            else
                w = pick_gap();
            if (w > 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL two_cluster_online_kmeans");
        $finish;
    end

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        mode        <= MODE_LOAD;
        point_x     <= '0;
        point_y     <= '0;
        point_index <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        mismatches  = 0;
        sent_words  = 0;
        steady      = 1'b0;
        hold_req    = 0;
        pt_count    = 0;
        pass_cnt    = 0;
        conv_flag   = 1'b0;
        fresh_set   = 1'b1;
        pass_lim    = PASS_LIMIT_RESET;
        for (int k = 0; k < 4; k++)
            cen[k] = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_too_few_points();
        test_extreme_coords();
        test_pass_limits();
        test_store_full();
        test_backpressure();
        test_random_sets();

        drain_block();
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("PASS two_cluster_online_kmeans");
        else
            $display("FAIL two_cluster_online_kmeans");
        $finish;
    end

endmodule
